@@ rtl/bc_pkg.sv @@
// ============================================================================
// bc_pkg: shared types and constants of the bit crusher
// Register indexes, configuration field widths and the control bundle that
// carries the quantizer and rate-reduction settings to the hold stage.
// ============================================================================
package bc_pkg;

    // Configuration register field widths.
    localparam int QUANT_BITS_W = 5;
    localparam int DOWNSAMPLE_W = 5;
    localparam int WET_MIX_W    = 17;
    localparam int CFG_IDX_W    = 2;

    // Unity gain of the wet mix in unsigned Q1.16.
    localparam logic [WET_MIX_W-1:0] MIX_UNITY = 17'd65536;

    // Reset values of the configuration registers.
    localparam logic [QUANT_BITS_W-1:0] QUANT_BITS_RST = 5'd16;
    localparam logic [DOWNSAMPLE_W-1:0] DOWNSAMPLE_RST = 5'd1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUANT_BITS = 2'd0,
        REG_DOWNSAMPLE = 2'd1,
        REG_WET_MIX    = 2'd2
    } cfg_reg_t;

    // Settings used by the sample-and-hold stage.
    typedef struct packed {
        logic [QUANT_BITS_W-1:0] quant_bits;
        logic [DOWNSAMPLE_W-1:0] downsample_factor;
    } hold_cfg_t;

endpackage

@@ rtl/bit_crusher.sv @@
// ============================================================================
// bit_crusher: stereo bitcrusher with dry/wet mix
// Sample-and-hold rate reduction and rounding quantizer per channel, mixed
// with the dry signal in fixed point.
// ============================================================================
//
//  Channel   Direction  Ports                        Contents
//  s_        in         s_tvalid s_tready s_tdata    sample_in, chan in s_tuser
//  m_        out        m_tvalid m_tready m_tdata    sample_out
//  cfg_      in         cfg_wr_en cfg_addr cfg_wdata register writes
//
//  One transaction is accepted per cycle while s_tready is high; each result
//  passes from its input transaction through the input register, the hold
//  stage, the multiplier stage and the output register.
//  Every stage holds its data while the next one is full, so the block keeps
//  accepting until all four stages are occupied.
//  Reset is synchronous, active low; it empties the pipeline, clears both
//  channels' counters and held samples, and loads the register defaults.
//
module bit_crusher #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int MAX_DOWNSAMPLE = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,  // sample_in
    input  logic                                   s_tuser,  // chan
    // Result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_tdata,  // sample_out
    // Configuration writes
    input  logic                                   cfg_wr_en,
    input  logic [bc_pkg::CFG_IDX_W-1:0]           cfg_addr,
    input  logic [bc_pkg::WET_MIX_W-1:0]           cfg_wdata
);
    import bc_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    logic [QUANT_BITS_W-1:0] quant_bits_reg;
    logic [DOWNSAMPLE_W-1:0] downsample_reg;
    logic [WET_MIX_W-1:0]    wet_mix_reg;

    logic                    in_valid_reg;
    logic signed [SW-1:0]    in_sample_reg;
    logic                    in_chan_reg;

    hold_cfg_t               hold_cfg;
    logic                    hold_in_ready;
    logic                    hold_valid;
    logic                    mix_in_ready;
    logic signed [SW-1:0]    hold_dry;
    logic signed [SW-1:0]    hold_held;
    logic signed [SW-1:0]    mix_out;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quant_bits_reg <= QUANT_BITS_RST;
            downsample_reg <= DOWNSAMPLE_RST;
            wet_mix_reg    <= MIX_UNITY;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_QUANT_BITS: quant_bits_reg <= cfg_wdata[QUANT_BITS_W-1:0];
                REG_DOWNSAMPLE: downsample_reg <= cfg_wdata[DOWNSAMPLE_W-1:0];
                REG_WET_MIX:    wet_mix_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    assign s_tready = !in_valid_reg || hold_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_tdata[SW-1:0];
            in_chan_reg   <= s_tuser;
        end
    end

    assign hold_cfg.quant_bits        = quant_bits_reg;
    assign hold_cfg.downsample_factor = downsample_reg;

    // Per-channel sample-and-hold stage.
    bc_hold #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .MAX_DOWNSAMPLE (MAX_DOWNSAMPLE)
    ) u_hold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (hold_cfg),
        .in_valid  (in_valid_reg),
        .in_ready  (hold_in_ready),
        .in_dry    (in_sample_reg),
        .in_chan   (in_chan_reg),
        .out_valid (hold_valid),
        .out_ready (mix_in_ready),
        .out_dry   (hold_dry),
        .out_held  (hold_held)
    );

    // Dry/wet mixer stages.
    bc_mix #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wet_mix    (wet_mix_reg),
        .in_valid   (hold_valid),
        .in_ready   (mix_in_ready),
        .in_dry     (hold_dry),
        .in_held    (hold_held),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (mix_out)
    );

    assign m_tdata = DATA_W'(unsigned'(mix_out));

endmodule

@@ rtl/bc_hold.sv @@
// ============================================================================
// bc_hold: per-channel sample-and-hold with quantizer
// Keeps a tick counter and a held sample for each channel, takes a new
// rounded sample when the counter reaches the downsample factor, and
// registers the dry and held samples for the mix stage.
// ============================================================================
module bc_hold #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int MAX_DOWNSAMPLE = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bc_pkg::hold_cfg_t             cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] in_dry,
    input  logic                          in_chan,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] out_dry,
    output logic signed [SAMPLE_WIDTH-1:0] out_held
);
    import bc_pkg::*;

    localparam int SW      = SAMPLE_WIDTH;
    localparam int FAC_MAX = (MAX_DOWNSAMPLE < 31) ? MAX_DOWNSAMPLE : 31;
    localparam int CNT_W   = $clog2(FAC_MAX + 1);
    localparam int SH_W    = $clog2(SAMPLE_WIDTH);

    logic [CNT_W-1:0]       tick_reg [2];
    logic signed [SW-1:0]   held_reg [2];
    logic                   valid_reg;
    logic signed [SW-1:0]   dry_reg;
    logic signed [SW-1:0]   held_out_reg;

    logic                   advance;
    logic [CNT_W-1:0]       fac;
    logic [CNT_W:0]         tick_inc;
    logic [CNT_W-1:0]       tick_next;
    logic                   take;
    logic                   bypass;
    logic [SH_W-1:0]        sh;
    logic signed [SW-1:0]   quant_val;
    logic signed [SW-1:0]   held_next;

    assign in_ready  = !valid_reg || out_ready;
    assign advance   = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_dry   = dry_reg;
    assign out_held  = held_out_reg;

    // Effective factor: zero acts as one, large values saturate.
    always_comb begin
        if (cfg.downsample_factor == '0) begin
            fac = CNT_W'(1);
        end else if (int'(cfg.downsample_factor) > FAC_MAX) begin
            fac = CNT_W'(FAC_MAX);
        end else begin
            fac = CNT_W'(cfg.downsample_factor);
        end
    end

    // Tick counter update for the selected channel.
    always_comb begin
        tick_inc = {1'b0, tick_reg[in_chan]} + (CNT_W+1)'(1);
        take     = tick_inc >= {1'b0, fac};
        if (take) begin
            tick_next = CNT_W'(tick_inc - {1'b0, fac});
        end else begin
            tick_next = tick_inc[CNT_W-1:0];
        end
    end

    // Round half up to the kept fractional bits, saturating at the top code; SW-1 or more bits bypass.
    always_comb begin
        logic [SW:0]        stepv;
        logic signed [SW:0] xw;
        logic signed [SW:0] r;
        logic signed [SW:0] top;
        bypass = int'(cfg.quant_bits) >= SW - 1;
        sh     = SH_W'(SW - 1) - cfg.quant_bits[SH_W-1:0];
        stepv  = (SW+1)'(1) << sh;
        xw     = {in_dry[SW-1], in_dry};
        r      = xw + signed'(stepv >> 1);
        r      = r & signed'(~(stepv - (SW+1)'(1)));
        top    = signed'((SW+1)'(1) << (SW - 1)) - signed'(stepv);
        if (r > top) begin
            r = top;
        end
        if (bypass) begin
            quant_val = in_dry;
        end else begin
            quant_val = r[SW-1:0];
        end
    end

    assign held_next = take ? quant_val : held_reg[in_chan];

    // Channel state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg[0] <= '0;
            tick_reg[1] <= '0;
            held_reg[0] <= '0;
            held_reg[1] <= '0;
        end else if (advance) begin
            tick_reg[in_chan] <= tick_next;
            held_reg[in_chan] <= held_next;
        end
    end

    // Stage valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            dry_reg      <= in_dry;
            held_out_reg <= held_next;
        end
    end

endmodule

@@ rtl/bc_mix.sv @@
// ============================================================================
// bc_mix: dry/wet mixer
// Weights the dry and held samples by the wet mix in one stage of
// multipliers, then adds, rounds and scales into the output register.
// ============================================================================
module bc_mix #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [bc_pkg::WET_MIX_W-1:0]          wet_mix,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]        in_dry,
    input  logic signed [SAMPLE_WIDTH-1:0]        in_held,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]        out_sample
);
    import bc_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int PW    = SW + WET_MIX_W + 1;
    localparam int SUM_W = PW + 1;

    logic                   prod_valid_reg;
    logic signed [PW-1:0]   prod_dry_reg;
    logic signed [PW-1:0]   prod_wet_reg;
    logic                   out_valid_reg;
    logic signed [SW-1:0]   out_reg;

    logic                   prod_ready;
    logic [WET_MIX_W-1:0]   mix_sat;
    logic [WET_MIX_W-1:0]   dry_gain;
    logic signed [SUM_W-1:0] sum;

    assign prod_ready = !out_valid_reg || out_ready;
    assign in_ready   = !prod_valid_reg || prod_ready;
    assign out_valid  = out_valid_reg;
    assign out_sample = out_reg;

    // Mix weights, saturated at unity.
    assign mix_sat  = (wet_mix > MIX_UNITY) ? MIX_UNITY : wet_mix;
    assign dry_gain = MIX_UNITY - mix_sat;

    // Sum with rounding offset; the output takes bits above the Q1.16 point.
    assign sum = SUM_W'(prod_dry_reg) + SUM_W'(prod_wet_reg) + SUM_W'(32768);

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (prod_ready) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    // Multiplier stage.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            prod_dry_reg <= PW'(in_dry * signed'({1'b0, dry_gain}));
            prod_wet_reg <= PW'(in_held * signed'({1'b0, mix_sat}));
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (prod_valid_reg && prod_ready) begin
            out_reg <= sum[SW+15:16];
        end
    end

endmodule

@@ rtl/bc_checker.sv @@
// ============================================================================
// bc_checker: port-level checks of the bit crusher
// Tracks transactions in flight from the ports and checks reset, stall and
// pipeline occupancy behavior.
// ============================================================================
module bc_checker #(
    parameter int DATA_W = 24
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata
);

    localparam logic [3:0] DEPTH = 4'd4;

    logic [3:0] inflight_reg;
    logic [3:0] inflight_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // Count of accepted transactions whose result is not yet delivered.
    always_comb begin
        inflight_next = inflight_reg;
        if (in_xfer && !out_xfer) begin
            inflight_next = inflight_reg + 4'd1;
        end else if (out_xfer && !in_xfer) begin
            inflight_next = inflight_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds its data.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // No result without an accepted transaction behind it.
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> inflight_reg != 4'd0)
        else $error("result with nothing in flight");

    // The pipeline never holds more than its four stages.
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= DEPTH)
        else $error("more transactions in flight than stages");

    // An empty pipeline always accepts.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg == 4'd0 |-> s_tready)
        else $error("input stalled while pipeline empty");

endmodule

bind bit_crusher bc_checker #(
    .DATA_W (((SAMPLE_WIDTH + 7) / 8) * 8)
) u_bc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
